### sv/tcs_pkg.sv
// Shared types, constants and step table for the thruster cleaning sequencer.
package tcs_pkg;

  localparam int TIME_BITS_DEF = 32;

  localparam int REQ_W    = 2;
  localparam int NOW_W    = 32;
  localparam int SPEED_W  = 8;
  localparam int STEP_W   = 4;
  localparam int STATUS_W = 4;
  localparam int POWER_W  = 7;
  localparam int DUR_W    = 16;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_MAX_SPEED    = 3'd0;
  localparam logic [2:0] REG_BURST_TIME   = 3'd1;
  localparam logic [2:0] REG_SETTLE_TIME  = 3'd2;
  localparam logic [2:0] REG_PAUSE_TIME   = 3'd3;
  localparam logic [2:0] REG_WAKE_TIMEOUT = 3'd4;

  localparam logic [7:0]       MAX_SPEED_RST    = 8'd0;
  localparam logic [DUR_W-1:0] BURST_TIME_RST   = 16'd2000;
  localparam logic [DUR_W-1:0] SETTLE_TIME_RST  = 16'd400;
  localparam logic [DUR_W-1:0] PAUSE_TIME_RST   = 16'd100;
  localparam logic [DUR_W-1:0] WAKE_TIMEOUT_RST = 16'd8000;

  localparam logic [7:0]         POWER_LIMIT = 8'd100;
  localparam logic [POWER_W-1:0] POWER_CLAMP = 7'd100;

  // Request types
  localparam logic [REQ_W-1:0] REQ_SERVICE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ABORT   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_NONE         = 4'd0;
  localparam logic [STATUS_W-1:0] ST_STARTED      = 4'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED      = 4'd2;
  localparam logic [STATUS_W-1:0] ST_REFUSED_CAL  = 4'd3;
  localparam logic [STATUS_W-1:0] ST_REFUSED_PWR  = 4'd4;
  localparam logic [STATUS_W-1:0] ST_ABORTED      = 4'd5;
  localparam logic [STATUS_W-1:0] ST_WAITING      = 4'd6;
  localparam logic [STATUS_W-1:0] ST_SUPPLY_UP    = 4'd7;
  localparam logic [STATUS_W-1:0] ST_STEP_ADVANCE = 4'd8;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT      = 4'd9;
  localparam logic [STATUS_W-1:0] ST_DONE         = 4'd10;

  localparam logic [STEP_W-1:0] STEP_LAST = 4'd8;

  // Thruster directions
  localparam logic [1:0] DIR_STOP = 2'b00;
  localparam logic [1:0] DIR_FWD  = 2'b01;
  localparam logic [1:0] DIR_REV  = 2'b11;

  // Step durations
  localparam logic [1:0] KIND_SETTLE = 2'd0;
  localparam logic [1:0] KIND_BURST  = 2'd1;
  localparam logic [1:0] KIND_PAUSE  = 2'd2;

  typedef struct packed {
    logic [7:0]       max_speed;
    logic [DUR_W-1:0] burst_time;
    logic [DUR_W-1:0] settle_time;
    logic [DUR_W-1:0] pause_time;
    logic [DUR_W-1:0] wake_timeout;
  } cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [NOW_W-1:0] now_ms;
    logic             esc_powered;
    logic             calibrating;
  } in_item_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed_bb;
    logic signed [SPEED_W-1:0] speed_sb;
    logic                      active;
    logic                      wake_request;
    logic [STEP_W-1:0]         step_index;
    logic [STATUS_W-1:0]       status;
  } res_t;

  function automatic logic [1:0] step_dir_bb(input logic [STEP_W-1:0] s);
    case (s)
      4'd1:    step_dir_bb = DIR_REV;
      4'd3:    step_dir_bb = DIR_FWD;
      4'd5:    step_dir_bb = DIR_REV;
      default: step_dir_bb = DIR_STOP;
    endcase
  endfunction

  function automatic logic [1:0] step_dir_sb(input logic [STEP_W-1:0] s);
    case (s)
      4'd1:    step_dir_sb = DIR_REV;
      4'd3:    step_dir_sb = DIR_FWD;
      4'd7:    step_dir_sb = DIR_REV;
      default: step_dir_sb = DIR_STOP;
    endcase
  endfunction

  function automatic logic [1:0] step_kind(input logic [STEP_W-1:0] s);
    case (s)
      4'd1, 4'd3, 4'd5, 4'd7: step_kind = KIND_BURST;
      4'd2:                   step_kind = KIND_PAUSE;
      default:                step_kind = KIND_SETTLE;
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] step_len(input cfg_t c, input logic [STEP_W-1:0] s);
    case (step_kind(s))
      KIND_BURST: step_len = c.burst_time;
      KIND_PAUSE: step_len = c.pause_time;
      default:    step_len = c.settle_time;
    endcase
  endfunction

  function automatic logic signed [SPEED_W-1:0] speed_cmd(input logic [1:0] dir,
                                                          input logic [POWER_W-1:0] pw);
    case (dir)
      DIR_FWD: speed_cmd = {1'b0, pw};
      DIR_REV: speed_cmd = 8'(8'd0 - {1'b0, pw});
      default: speed_cmd = '0;
    endcase
  endfunction

endpackage

### sv/tcs_if.sv
// Valid/ready channel interfaces for request items and result items.
interface tcs_in_if;
  import tcs_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [NOW_W-1:0] now_ms;
  logic             esc_powered;
  logic             calibrating;

  modport source (output valid, req_type, now_ms, esc_powered, calibrating, input ready);
  modport sink   (input valid, req_type, now_ms, esc_powered, calibrating, output ready);
endinterface

interface tcs_out_if;
  import tcs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] speed_bb;
  logic signed [SPEED_W-1:0] speed_sb;
  logic                      active;
  logic                      wake_request;
  logic [STEP_W-1:0]         step_index;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, speed_bb, speed_sb, active, wake_request, step_index, status,
                  input ready);
  modport sink   (input valid, speed_bb, speed_sb, active, wake_request, step_index, status,
                  output ready);
endinterface

### sv/tcs_cfg_regs.sv
// APB-style configuration register file.
module tcs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [tcs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [tcs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [tcs_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output tcs_pkg::cfg_t                  cfg
);
  import tcs_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr;

  assign idx        = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_speed    <= MAX_SPEED_RST;
      cfg_r.burst_time   <= BURST_TIME_RST;
      cfg_r.settle_time  <= SETTLE_TIME_RST;
      cfg_r.pause_time   <= PAUSE_TIME_RST;
      cfg_r.wake_timeout <= WAKE_TIMEOUT_RST;
    end else if (wr) begin
      case (idx)
        REG_MAX_SPEED:    cfg_r.max_speed    <= cfg_pwdata[7:0];
        REG_BURST_TIME:   cfg_r.burst_time   <= cfg_pwdata[DUR_W-1:0];
        REG_SETTLE_TIME:  cfg_r.settle_time  <= cfg_pwdata[DUR_W-1:0];
        REG_PAUSE_TIME:   cfg_r.pause_time   <= cfg_pwdata[DUR_W-1:0];
        REG_WAKE_TIMEOUT: cfg_r.wake_timeout <= cfg_pwdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAX_SPEED:    cfg_prdata = {24'd0, cfg_r.max_speed};
      REG_BURST_TIME:   cfg_prdata = {16'd0, cfg_r.burst_time};
      REG_SETTLE_TIME:  cfg_prdata = {16'd0, cfg_r.settle_time};
      REG_PAUSE_TIME:   cfg_prdata = {16'd0, cfg_r.pause_time};
      REG_WAKE_TIMEOUT: cfg_prdata = {16'd0, cfg_r.wake_timeout};
      default:          cfg_prdata = '0;
    endcase
  end

endmodule

### sv/tcs_in_reg.sv
// Input register: captures one request item per transfer.
module tcs_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  tcs_in_if.sink              in_ch,
  input  logic                take,
  output logic                item_valid,
  output tcs_pkg::in_item_t   item
);
  import tcs_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  assign in_ch.ready = !valid_r || take;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.req_type    <= in_ch.req_type;
      item_r.now_ms      <= in_ch.now_ms;
      item_r.esc_powered <= in_ch.esc_powered;
      item_r.calibrating <= in_ch.calibrating;
    end
  end

endmodule

### sv/tcs_step_core.sv
// Routine state and the per-item decision logic.
module tcs_step_core #(
  parameter int TIME_BITS = tcs_pkg::TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  tcs_pkg::in_item_t item,
  input  tcs_pkg::cfg_t     cfg,
  output tcs_pkg::res_t     res
);
  import tcs_pkg::*;

  logic                 running_r, running_nxt;
  logic                 waking_r, waking_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [TIME_BITS-1:0] step_dl_r, step_dl_nxt;
  logic [TIME_BITS-1:0] wake_dl_r, wake_dl_nxt;
  logic [POWER_W-1:0]   power_r, power_nxt;

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] step_diff;
  logic [TIME_BITS-1:0] wake_diff;
  logic                 step_hit;
  logic                 wake_hit;
  logic [STEP_W-1:0]    step_cl;
  logic [STEP_W-1:0]    step_inc;
  logic [POWER_W-1:0]   clamp;
  logic                 finished;

  assign now       = TIME_BITS'(item.now_ms);
  assign step_diff = now - step_dl_r;
  assign wake_diff = now - wake_dl_r;
  // wrap-safe: reached once the difference is non-negative
  assign step_hit  = !step_diff[TIME_BITS-1];
  assign wake_hit  = !wake_diff[TIME_BITS-1];
  assign step_cl   = (step_r > STEP_LAST) ? STEP_LAST : step_r;
  assign step_inc  = 4'(step_cl + 4'd1);
  assign clamp     = (cfg.max_speed > POWER_LIMIT) ? POWER_CLAMP : cfg.max_speed[POWER_W-1:0];

  always_comb begin
    running_nxt      = running_r;
    waking_nxt       = waking_r;
    step_nxt         = step_r;
    step_dl_nxt      = step_dl_r;
    wake_dl_nxt      = wake_dl_r;
    power_nxt        = power_r;
    finished         = 1'b0;
    res.speed_bb     = '0;
    res.speed_sb     = '0;
    res.wake_request = 1'b0;
    res.status       = ST_NONE;

    case (item.req_type)
      REQ_START: begin
        if (running_r) begin
          res.status = ST_IGNORED;
        end else if (item.calibrating) begin
          res.status = ST_REFUSED_CAL;
        end else begin
          power_nxt = clamp;
          if (clamp == '0) begin
            res.status = ST_REFUSED_PWR;
          end else begin
            running_nxt      = 1'b1;
            waking_nxt       = 1'b1;
            step_nxt         = '0;
            wake_dl_nxt      = now + TIME_BITS'(cfg.wake_timeout);
            step_dl_nxt      = now + TIME_BITS'(step_len(cfg, '0));
            res.wake_request = 1'b1;
            res.status       = ST_STARTED;
          end
        end
      end
      REQ_ABORT: begin
        if (running_r) begin
          running_nxt = 1'b0;
          waking_nxt  = 1'b0;
          res.status  = ST_ABORTED;
        end
      end
      REQ_SERVICE: begin
        if (running_r) begin
          if (waking_r) begin
            // supply up wins over the timeout
            if (item.esc_powered) begin
              waking_nxt  = 1'b0;
              step_dl_nxt = now + TIME_BITS'(step_len(cfg, '0));
              res.status  = ST_SUPPLY_UP;
            end else if (wake_hit) begin
              running_nxt = 1'b0;
              res.status  = ST_TIMEOUT;
            end else begin
              res.status  = ST_WAITING;
            end
          end else begin
            step_nxt = step_cl;
            if (step_hit) begin
              if (step_cl == STEP_LAST) begin
                running_nxt = 1'b0;
                finished    = 1'b1;
                res.status  = ST_DONE;
              end else begin
                step_nxt    = step_inc;
                step_dl_nxt = now + TIME_BITS'(step_len(cfg, step_inc));
                res.status  = ST_STEP_ADVANCE;
              end
            end
            if (!finished) begin
              res.speed_bb = speed_cmd(step_dir_bb(step_nxt), power_r);
              res.speed_sb = speed_cmd(step_dir_sb(step_nxt), power_r);
            end
          end
        end
      end
      default: ;
    endcase

    res.active     = running_nxt;
    res.step_index = step_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      waking_r  <= 1'b0;
      step_r    <= '0;
      step_dl_r <= '0;
      wake_dl_r <= '0;
      power_r   <= '0;
    end else if (en) begin
      running_r <= running_nxt;
      waking_r  <= waking_nxt;
      step_r    <= step_nxt;
      step_dl_r <= step_dl_nxt;
      wake_dl_r <= wake_dl_nxt;
      power_r   <= power_nxt;
    end
  end

endmodule

### sv/tcs_out_reg.sv
// Result register: holds one result until the receiver takes it.
module tcs_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  tcs_pkg::res_t res,
  output logic          can_load,
  tcs_out_if.source     out_ch
);
  import tcs_pkg::*;

  logic valid_r;
  res_t res_r;

  assign can_load            = !valid_r || out_ch.ready;
  assign out_ch.valid        = valid_r;
  assign out_ch.speed_bb     = res_r.speed_bb;
  assign out_ch.speed_sb     = res_r.speed_sb;
  assign out_ch.active       = res_r.active;
  assign out_ch.wake_request = res_r.wake_request;
  assign out_ch.step_index   = res_r.step_index;
  assign out_ch.status       = res_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

### sv/thruster_clean_sequencer.sv
// Top level of the two-thruster cleaning sequencer.
//
// Usage:
//   in_ch  : request items (service tick, start, abort) with the current ms time,
//            the motor supply flag and the compass calibration flag.
//   out_ch : one result per request: both speed commands, run flag, wake pulse,
//            step number and a status code.
//   cfg_*  : APB-style register port; max_speed, burst_time, settle_time,
//            pause_time, wake_timeout at byte addresses 0, 4, 8, 12, 16.
//            Write only while no request is in flight.
// Timing:
//   A request transfers into the input register, is decided from there and
//   lands in the result register, which drives out_valid. One request per
//   cycle is sustained while out_ch.ready stays high; the routine state is
//   updated at the same edge that loads the result, so the next request sees it.
// Reset (rst_n low, synchronous): clears the run state and both pipeline valid
//   flags and returns the registers to their default values.
// Stall: a result that is not taken holds in the result register; one more
//   request may wait in the input register, then in_ch.ready drops.
module thruster_clean_sequencer #(
  parameter int TIME_BITS = tcs_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tcs_in_if.sink                         in_ch,
  tcs_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [tcs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [tcs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [tcs_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import tcs_pkg::*;

  cfg_t     cfg;
  in_item_t item;
  res_t     res;
  logic     item_valid;
  logic     can_load;
  logic     take;

  // advance the held request when the result register has room
  assign take = item_valid && can_load;

  tcs_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  tcs_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // decide the request and commit the routine state on the same edge
  tcs_step_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (take),
    .item  (item),
    .cfg   (cfg),
    .res   (res)
  );

  tcs_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take),
    .res      (res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

### sv/tcs_checker.sv
// Port-level checks for the cleaning sequencer, bound to the top level.
module tcs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [tcs_pkg::SPEED_W-1:0] out_speed_bb,
  input logic signed [tcs_pkg::SPEED_W-1:0] out_speed_sb,
  input logic                              out_active,
  input logic                              out_wake_request,
  input logic [tcs_pkg::STEP_W-1:0]        out_step_index,
  input logic [tcs_pkg::STATUS_W-1:0]      out_status
);
  import tcs_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_step_index) && $stable(out_speed_bb))
    else $error("stalled result changed");

  // a wake pulse only comes with a fresh start at step zero
  a_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wake_request |->
    out_status == ST_STARTED && out_active && out_step_index == '0)
    else $error("wake request without start");

  // thrusters stay quiet whenever the routine is not running
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_active |-> out_speed_bb == '0 && out_speed_sb == '0)
    else $error("speed command while idle");

  // completion stops the run on the last step
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DONE |-> !out_active && out_step_index == STEP_LAST)
    else $error("bad completion result");

endmodule

bind thruster_clean_sequencer tcs_checker u_tcs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_speed_bb     (out_ch.speed_bb),
  .out_speed_sb     (out_ch.speed_sb),
  .out_active       (out_ch.active),
  .out_wake_request (out_ch.wake_request),
  .out_step_index   (out_ch.step_index),
  .out_status       (out_ch.status)
);

### test/tb.sv
// Self-checking testbench for the two-thruster cleaning sequencer.
module tb;
  import tcs_pkg::*;

  // Request code that the block has to ignore.
  localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
  // Cycles with no transfer on either channel before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Cycles to hold after the last result before a register write or the end.
  localparam int PIPE_TAIL = 4;

  // Routine predictor and result checker. The state below tracks the block's
  // own run state; results are queued in request order and matched in order.
  class clean_scoreboard;
    cfg_t                 regs;
    bit                   running;
    bit                   waking;
    logic [STEP_W-1:0]    step_no;
    logic [NOW_W-1:0]     step_due;
    logic [NOW_W-1:0]     wake_due;
    logic [POWER_W-1:0]   power;
    res_t                 due_results[$];
    int                   fails;

    function new();
      regs.max_speed    = MAX_SPEED_RST;
      regs.burst_time   = BURST_TIME_RST;
      regs.settle_time  = SETTLE_TIME_RST;
      regs.pause_time   = PAUSE_TIME_RST;
      regs.wake_timeout = WAKE_TIMEOUT_RST;
      running  = 1'b0;
      waking   = 1'b0;
      step_no  = '0;
      step_due = '0;
      wake_due = '0;
      power    = '0;
      fails    = 0;
    endfunction

    // Duration of each step: bursts on the odd steps, the short pause after
    // the astern burst, settle everywhere else.
    function logic [DUR_W-1:0] hold_ms(logic [STEP_W-1:0] s);
      case (s)
        4'd1, 4'd3, 4'd5, 4'd7: return regs.burst_time;
        4'd2:                   return regs.pause_time;
        default:                return regs.settle_time;
      endcase
    endfunction

    function int port_dir(logic [STEP_W-1:0] s);
      case (s)
        4'd1, 4'd5: return -1;
        4'd3:       return 1;
        default:    return 0;
      endcase
    endfunction

    function int stbd_dir(logic [STEP_W-1:0] s);
      case (s)
        4'd1, 4'd7: return -1;
        4'd3:       return 1;
        default:    return 0;
      endcase
    endfunction

    function logic signed [SPEED_W-1:0] thrust(int dir);
      return SPEED_W'(dir * int'(power));
    endfunction

    // Wrap-safe compare: the deadline is reached when now - due has a clear top bit.
    function bit deadline_hit(logic [NOW_W-1:0] now, logic [NOW_W-1:0] due);
      logic [NOW_W-1:0] diff;
      diff = now - due;
      return !diff[NOW_W-1];
    endfunction

    // Advance the predicted state by one accepted request and queue its result.
    function void note_request(in_item_t rq);
      res_t r;
      bit   finished;
      r = '0;
      finished = 1'b0;
      case (rq.req_type)
        REQ_START: begin
          if (running) begin
            r.status = ST_IGNORED;
          end else if (rq.calibrating) begin
            r.status = ST_REFUSED_CAL;
          end else begin
            power = (regs.max_speed > POWER_LIMIT) ? POWER_CLAMP
                                                   : regs.max_speed[POWER_W-1:0];
            if (power == '0) begin
              r.status = ST_REFUSED_PWR;
            end else begin
              running        = 1'b1;
              waking         = 1'b1;
              step_no        = '0;
              r.wake_request = 1'b1;
              wake_due       = rq.now_ms + NOW_W'(regs.wake_timeout);
              step_due       = rq.now_ms + NOW_W'(hold_ms('0));
              r.status       = ST_STARTED;
            end
          end
        end
        REQ_ABORT: begin
          if (running) begin
            running  = 1'b0;
            waking   = 1'b0;
            r.status = ST_ABORTED;
          end
        end
        REQ_SERVICE: begin
          if (running && waking) begin
            // Supply up wins over the wake timeout.
            if (rq.esc_powered) begin
              waking   = 1'b0;
              step_due = rq.now_ms + NOW_W'(hold_ms('0));
              r.status = ST_SUPPLY_UP;
            end else if (deadline_hit(rq.now_ms, wake_due)) begin
              running  = 1'b0;
              r.status = ST_TIMEOUT;
            end else begin
              r.status = ST_WAITING;
            end
          end else if (running) begin
            if (deadline_hit(rq.now_ms, step_due)) begin
              if (step_no == STEP_LAST) begin
                running  = 1'b0;
                finished = 1'b1;
                r.status = ST_DONE;
              end else begin
                step_no++;
                step_due = rq.now_ms + NOW_W'(hold_ms(step_no));
                r.status = ST_STEP_ADVANCE;
              end
            end
            if (!finished) begin
              r.speed_bb = thrust(port_dir(step_no));
              r.speed_sb = thrust(stbd_dir(step_no));
            end
          end
        end
        default: ;
      endcase
      r.active     = running;
      r.step_index = step_no;
      due_results.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        fails++;
        return;
      end
      want = due_results.pop_front();
      if (got.speed_bb !== want.speed_bb) begin
        $error("speed_bb: expected %0d, got %0d", want.speed_bb, got.speed_bb);
        fails++;
      end
      if (got.speed_sb !== want.speed_sb) begin
        $error("speed_sb: expected %0d, got %0d", want.speed_sb, got.speed_sb);
        fails++;
      end
      if (got.active !== want.active) begin
        $error("active: expected %0d, got %0d", want.active, got.active);
        fails++;
      end
      if (got.wake_request !== want.wake_request) begin
        $error("wake_request: expected %0d, got %0d", want.wake_request, got.wake_request);
        fails++;
      end
      if (got.step_index !== want.step_index) begin
        $error("step_index: expected %0d, got %0d", want.step_index, got.step_index);
        fails++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  tcs_in_if  in_ch ();
  tcs_out_if out_ch ();

  clean_scoreboard  sb;
  res_t             seen;
  bit               idle_on;
  int               stall_left = 0;
  int               quiet = 0;
  int               sent = 0;
  logic [NOW_W-1:0] clock_ms;

  thruster_clean_sequencer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #4 clk = ~clk;

  // Result sink: stall at random times while idling is enabled.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      out_ch.ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 9);
      out_ch.ready  <= 1'b0;
    end else begin
      out_ch.ready  <= 1'b1;
    end
  end

  // Check every result transfer against the oldest predicted result.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen.speed_bb     = out_ch.speed_bb;
      seen.speed_sb     = out_ch.speed_sb;
      seen.active       = out_ch.active;
      seen.wake_request = out_ch.wake_request;
      seen.step_index   = out_ch.step_index;
      seen.status       = out_ch.status;
      sb.check_result(seen);
    end
  end

  // Watchdog: end the run once nothing has transferred for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Present one request and hold it until it transfers; optionally idle first.
  task automatic push_req(logic [REQ_W-1:0] kind, logic [NOW_W-1:0] now,
                          logic esc, logic cal);
    in_item_t rq;
    rq.req_type    = kind;
    rq.now_ms      = now;
    rq.esc_powered = esc;
    rq.calibrating = cal;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= kind;
    in_ch.now_ms      <= now;
    in_ch.esc_powered <= esc;
    in_ch.calibrating <= cal;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(rq);
    sent++;
  endtask

  // Drop valid and wait until every predicted result has arrived, then let
  // the pipeline empty.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (PIPE_TAIL) @(posedge clk);
  endtask

  // Write one register (junk in the unused upper bits) and read it back.
  task automatic write_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] val);
    logic [CFG_DATA_W-1:0] kept;
    kept = (idx == REG_MAX_SPEED) ? {24'd0, val[7:0]} : {16'd0, val[15:0]};
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    case (idx)
      REG_MAX_SPEED:    sb.regs.max_speed    = val[7:0];
      REG_BURST_TIME:   sb.regs.burst_time   = val[DUR_W-1:0];
      REG_SETTLE_TIME:  sb.regs.settle_time  = val[DUR_W-1:0];
      REG_PAUSE_TIME:   sb.regs.pause_time   = val[DUR_W-1:0];
      REG_WAKE_TIMEOUT: sb.regs.wake_timeout = val[DUR_W-1:0];
      default: ;
    endcase
    // Keep psel high and turn the bus around into a read of the same register.
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata !== kept) begin
      $error("register %0d: expected %0h, got %0h", idx, kept, cfg_prdata);
      sb.fails++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    // Return the bus to idle before the next access.
    @(posedge clk);
  endtask

  // Reprogram every register while the block is idle.
  task automatic set_regs(logic [7:0] spd, logic [DUR_W-1:0] burst, logic [DUR_W-1:0] stl,
                          logic [DUR_W-1:0] pse, logic [DUR_W-1:0] wake);
    logic [31:0] junk;
    drain_results();
    junk = $urandom;
    write_reg(REG_MAX_SPEED, {junk[31:8], spd});
    write_reg(REG_BURST_TIME, {junk[31:16], burst});
    write_reg(REG_SETTLE_TIME, {junk[15:0], stl});
    write_reg(REG_PAUSE_TIME, {junk[23:8], pse});
    write_reg(REG_WAKE_TIMEOUT, {junk[27:12], wake});
  endtask

  // One well-formed routine from a random start time: start, a few waits,
  // supply up, then ticks that step through the table. Sprinkle aborts,
  // repeated starts and reserved requests into the run.
  task automatic run_routine();
    int span;
    int wspan;
    int ticks;
    int pick;
    span = int'(sb.regs.burst_time);
    if (int'(sb.regs.settle_time) > span) span = int'(sb.regs.settle_time);
    if (int'(sb.regs.pause_time) > span) span = int'(sb.regs.pause_time);
    span  = span / 2 + 1;
    wspan = int'(sb.regs.wake_timeout) / 2 + 1;
    clock_ms = $urandom;
    push_req(REQ_START, clock_ms, 1'($urandom_range(0, 1)), 1'b0);
    repeat ($urandom_range(0, 3)) begin
      clock_ms += NOW_W'($urandom_range(0, wspan));
      push_req(REQ_SERVICE, clock_ms, 1'b0, 1'($urandom_range(0, 1)));
    end
    clock_ms += NOW_W'($urandom_range(0, 3));
    push_req(REQ_SERVICE, clock_ms, 1'b1, 1'($urandom_range(0, 1)));
    ticks = 0;
    while (sb.running && ticks < 60) begin
      pick = $urandom_range(0, 39);
      if (pick == 0) begin
        push_req(REQ_ABORT, clock_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (pick == 1) begin
        push_req(REQ_START, clock_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (pick == 2) begin
        push_req(REQ_RESERVED, clock_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        clock_ms += NOW_W'($urandom_range(0, span));
        push_req(REQ_SERVICE, clock_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      ticks++;
    end
  endtask

  // Mostly whole routines; the rest is loose requests of any kind.
  task automatic random_requests(int count);
    int target;
    int pick;
    target = sent + count;
    while (sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        run_routine();
      end else if (pick == 7) begin
        push_req(REQ_W'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      end else if (pick == 8) begin
        push_req(REQ_START, $urandom, 1'($urandom_range(0, 1)), 1'b1);
      end else begin
        push_req(REQ_ABORT, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    sb                = new();
    idle_on           = 1'b1;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = REQ_SERVICE;
    in_ch.now_ms      = '0;
    in_ch.esc_powered = 1'b0;
    in_ch.calibrating = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: zero power refuses the start; idle service, idle abort,
    // and the reserved request type all leave the block untouched.
    push_req(REQ_START, '0, 1'b0, 1'b0);
    push_req(REQ_SERVICE, '1, 1'b1, 1'b1);
    push_req(REQ_ABORT, '0, 1'b0, 1'b0);
    push_req(REQ_RESERVED, '1, 1'b1, 1'b1);

    // Short steps and a clamped power; run across the time wrap.
    set_regs(8'd255, 16'd3, 16'd2, 16'd1, 16'd5);
    push_req(REQ_START, '0, 1'b0, 1'b1);
    clock_ms = 32'hFFFF_FFF0;
    push_req(REQ_START, clock_ms, 1'b0, 1'b0);
    push_req(REQ_START, clock_ms, 1'b0, 1'b0);
    push_req(REQ_SERVICE, clock_ms, 1'b0, 1'b0);
    // Wake timeout exactly at the deadline.
    push_req(REQ_SERVICE, clock_ms + 32'd5, 1'b0, 1'b0);
    clock_ms = clock_ms + 32'd6;
    push_req(REQ_START, clock_ms, 1'b0, 1'b0);
    push_req(REQ_SERVICE, clock_ms, 1'b1, 1'b0);
    // Step through to completion in ticks of 2 ms, some of them with no change.
    while (sb.running) begin
      clock_ms += NOW_W'(2);
      push_req(REQ_SERVICE, clock_ms, 1'b0, 1'b0);
    end
    push_req(REQ_START, clock_ms, 1'b0, 1'b0);
    push_req(REQ_ABORT, clock_ms, 1'b0, 1'b0);

    // Random phases over a range of register settings, extremes included.
    set_regs(8'd100, 16'd0, 16'd0, 16'd0, 16'd0);
    random_requests(110);
    set_regs(8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_requests(110);
    set_regs(8'd101, 16'd50, 16'd20, 16'd5, 16'd30);
    random_requests(110);
    set_regs(8'd0, 16'd10, 16'd10, 16'd10, 16'd10);
    random_requests(40);
    set_regs(8'd255, 16'd200, 16'd100, 16'd0, 16'd0);
    random_requests(110);
    set_regs(8'd37, 16'd7, 16'd3, 16'd1, 16'hFFFF);
    random_requests(110);
    // Last stretch at full rate on both channels.
    idle_on = 1'b0;
    set_regs(8'd100, 16'd2000, 16'd400, 16'd100, 16'd8000);
    random_requests(110);

    drain_results();
    if (sb.fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
sv/tcs_pkg.sv
sv/tcs_if.sv
sv/tcs_cfg_regs.sv
sv/tcs_in_reg.sv
sv/tcs_step_core.sv
sv/tcs_out_reg.sv
sv/thruster_clean_sequencer.sv
sv/tcs_checker.sv
test/tb.sv
